// ===== rtl/core/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGES      = 4096;
	localparam int MAX_RUN    = 64;
	localparam int WORD_W     = 64;
	localparam int WORDS      = PAGES / WORD_W;
	localparam int WIDX_W     = $clog2(WORDS);
	localparam int PIDX_W     = $clog2(PAGES);
	localparam int HINT_W     = PIDX_W + 1;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int CNT_W      = 7;
	localparam int ADDR_W     = 24;
	localparam int PAGE_SHIFT = 12;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	// classified request handed from front to back
	typedef struct packed {
		logic              valid_req; // request may touch the map
		func_t             func;
		logic [CNT_W-1:0]  cnt;
		logic [PIDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address_res;
		logic              ok;
	} res_t;

endpackage

// ===== rtl/core/bpa_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpa_front
// Accept request words, check count and range, push into a two-entry queue.
// ---------------------------------------------------------------------------
module bpa_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [bpa_pkg::CNT_W-1:0] page_count,
	input  logic [bpa_pkg::ADDR_W-1:0] address,
	output logic                      cmd_valid,
	output bpa_pkg::cmd_t             cmd,
	input  logic                      cmd_pop
);
	import bpa_pkg::*;

	cmd_t       q_mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic [PIDX_W:0] endp;
	logic       push;

	always_comb begin
		c.func = func_t'(func);
		c.cnt  = page_count;
		c.idx  = address[ADDR_W-1 -: PIDX_W];
		endp   = {1'b0, c.idx} + (PIDX_W+1)'(page_count);
		c.valid_req = (page_count != '0) && (page_count <= CNT_W'(MAX_RUN)) &&
			((func == FUNC_ALLOC) || (endp <= (PIDX_W+1)'(PAGES)));
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

// ===== rtl/core/bpa_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpa_back
// Map sequencer: clear sweep, first-fit word scan, run marking, hint upkeep.
// ---------------------------------------------------------------------------
module bpa_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bpa_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	output bpa_pkg::res_t res,
	input  logic          res_stall
);
	import bpa_pkg::*;

	typedef enum logic [8:0] {
		ST_CLR   = 9'b0_0000_0001,
		ST_IDLE  = 9'b0_0000_0010,
		ST_SRD   = 9'b0_0000_0100, // scan: read word issued
		ST_SCAN  = 9'b0_0000_1000,
		ST_MRD   = 9'b0_0001_0000, // mark/clear: read word
		ST_MWR   = 9'b0_0010_0000,
		ST_HRD   = 9'b0_0100_0000, // hint advance: read word issued
		ST_HSCAN = 9'b0_1000_0000,
		ST_DONE  = 9'b1_0000_0000
	} state_t;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [WIDX_W-1:0] raddr, waddr;
	logic              we;
	logic [WORD_W-1:0] wdata;

	state_t            st_q;
	logic [WIDX_W:0]   wptr_q;      // word pointer, one extra bit for end
	logic [PIDX_W:0]   page_q;      // page pointer during scan
	logic [HINT_W-1:0] hint_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  left_q;      // pages still to mark or clear
	logic [PIDX_W-1:0] start_q;
	logic [PIDX_W:0]   mpage_q;
	func_t             func_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rv_q;
	res_t              res_q;

	// step page by page through the registered word; skip whole used words
	logic [BIT_W-1:0]  bsel;
	logic              bit_used;
	logic              word_full;
	logic [PIDX_W:0]   next_word_page;
	logic [PIDX_W:0]   run_start;
	logic [WORD_W-1:0] mask;
	logic [BIT_W:0]    nbits;
	logic [BIT_W:0]    room;

	assign bsel           = page_q[BIT_W-1:0];
	assign bit_used       = rdata_q[bsel];
	assign word_full      = &rdata_q;
	assign next_word_page = {wptr_q + 1'b1, {BIT_W{1'b0}}};
	assign run_start      = page_q + (PIDX_W+1)'(1) - (PIDX_W+1)'(cnt_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// marking mask: from bit of mpage_q, up to min(left, room) bits
	always_comb begin
		room  = (BIT_W+1)'(WORD_W) - {1'b0, mpage_q[BIT_W-1:0]};
		nbits = (left_q > CNT_W'(room)) ? room : (BIT_W+1)'(left_q);
		mask  = ((nbits == (BIT_W+1)'(WORD_W)) ? {WORD_W{1'b1}} :
			((WORD_W'(1) << nbits) - WORD_W'(1))) << mpage_q[BIT_W-1:0];
	end

	always_comb begin
		raddr = wptr_q[WIDX_W-1:0];
		waddr = wptr_q[WIDX_W-1:0];
		we    = 1'b0;
		wdata = '0;
		unique case (st_q)
			ST_CLR: begin we = 1'b1; end
			ST_MWR: begin
				we    = 1'b1;
				wdata = (func_q == FUNC_FREE) ? (rdata_q & ~mask) : (rdata_q | mask);
			end
			default: ;
		endcase
	end

	assign cmd_pop   = (st_q == ST_IDLE) && cmd_valid && !rv_q;
	assign res_valid = rv_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; wptr_q <= '0; page_q <= '0; hint_q <= '0;
			run_q <= '0; left_q <= '0; start_q <= '0; mpage_q <= '0;
			func_q <= FUNC_ALLOC; cnt_q <= '0; rv_q <= 1'b0; res_q <= '0;
		end else begin
			if (st_q == ST_DONE) rv_q <= 1'b1;
			else if (rv_q && !res_stall) rv_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					wptr_q <= wptr_q + 1'b1;
					if (wptr_q == (WIDX_W+1)'(WORDS-1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						func_q <= cmd.func;
						cnt_q  <= cmd.cnt;
						if (!cmd.valid_req) begin
							res_q <= '{address_res: '0, ok: 1'b0};
							st_q  <= ST_DONE;
						end else if (cmd.func == FUNC_FREE) begin
							mpage_q <= {1'b0, cmd.idx};
							left_q  <= cmd.cnt;
							wptr_q  <= {1'b0, cmd.idx[PIDX_W-1 -: WIDX_W]};
							if ({1'b0, cmd.idx} < hint_q) hint_q <= {1'b0, cmd.idx};
							res_q   <= '{address_res: '0, ok: 1'b1};
							st_q    <= ST_MRD;
						end else if (hint_q >= HINT_W'(PAGES)) begin
							res_q <= '{address_res: '0, ok: 1'b0};
							st_q  <= ST_DONE;
						end else begin
							page_q <= hint_q[PIDX_W:0];
							wptr_q <= {1'b0, hint_q[PIDX_W-1 -: WIDX_W]};
							run_q  <= '0;
							st_q   <= ST_SRD;
						end
					end
				end
				ST_SRD: st_q <= ST_SCAN;
				ST_SCAN: begin
					if (page_q >= (PIDX_W+1)'(PAGES)) begin
						res_q <= '{address_res: '0, ok: 1'b0};
						st_q  <= ST_DONE;
					end else if (bit_used && word_full) begin
						// whole word used: skip it
						run_q  <= '0;
						page_q <= next_word_page;
						wptr_q <= wptr_q + 1'b1;
						st_q   <= ST_SRD;
					end else if (bit_used) begin
						run_q <= '0;
						page_q <= page_q + 1'b1;
						if (bsel == BIT_W'(WORD_W-1)) begin
							wptr_q <= wptr_q + 1'b1;
							st_q   <= ST_SRD;
						end
					end else if (run_q + 1'b1 == cnt_q) begin
						start_q <= run_start[PIDX_W-1:0];
						mpage_q <= run_start;
						left_q  <= cnt_q;
						wptr_q  <= {1'b0, run_start[PIDX_W-1 -: WIDX_W]};
						st_q    <= ST_MRD;
					end else begin
						run_q  <= run_q + 1'b1;
						page_q <= page_q + 1'b1;
						if (bsel == BIT_W'(WORD_W-1)) begin
							wptr_q <= wptr_q + 1'b1;
							st_q   <= ST_SRD;
						end
					end
				end
				ST_MRD: st_q <= ST_MWR;
				ST_MWR: begin
					left_q  <= left_q - CNT_W'(nbits);
					mpage_q <= mpage_q + (PIDX_W+1)'(nbits);
					if (left_q == CNT_W'(nbits)) begin
						if (func_q == FUNC_FREE) begin
							st_q <= ST_DONE;
						end else begin
							res_q <= '{address_res: ADDR_W'({start_q, {PAGE_SHIFT{1'b0}}}),
								ok: 1'b1};
							page_q <= hint_q[PIDX_W:0];
							wptr_q <= {1'b0, hint_q[PIDX_W-1 -: WIDX_W]};
							st_q   <= ST_HRD;
						end
					end else begin
						wptr_q <= wptr_q + 1'b1;
						st_q   <= ST_MRD;
					end
				end
				ST_HRD: st_q <= ST_HSCAN;
				// walk the hint forward to the lowest free page or the map end
				ST_HSCAN: begin
					if (page_q >= (PIDX_W+1)'(PAGES)) begin
						hint_q <= HINT_W'(PAGES);
						st_q   <= ST_DONE;
					end else if (!bit_used) begin
						hint_q <= page_q;
						st_q   <= ST_DONE;
					end else if (word_full) begin
						page_q <= next_word_page;
						wptr_q <= wptr_q + 1'b1;
						st_q   <= ST_HRD;
					end else begin
						page_q <= page_q + 1'b1;
						if (bsel == BIT_W'(WORD_W-1)) begin
							wptr_q <= wptr_q + 1'b1;
							st_q   <= ST_HRD;
						end
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/bitmap_page_allocator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page frame allocator over a 4096-bit used map held as 64 words.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | words
//  in      | input     | in_valid/in_stall  | func, page_count, address
//  out     | output    | out_valid/out_stall| address_res, ok
//
// After reset a sweep clears the map word by word; two requests queue meanwhile.
// Every request passes from queue pop through a done state to the result, plus
// map work: a free reads and writes back each word touched (one or two words).
// An allocate scans from the lowest-free hint one page a cycle, with a read
// state for each word entered and fully used words skipped whole, then writes
// the run back with a read and a write per word and walks the hint the same
// way. All map work goes through the single map port.
// A stalled result holds the back end; the queue then fills and stalls input.
// ---------------------------------------------------------------------------
module bitmap_page_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [bpa_pkg::CNT_W-1:0]   page_count,
	input  logic [bpa_pkg::ADDR_W-1:0]  address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bpa_pkg::ADDR_W-1:0]  address_res,
	output logic                        ok
);
	import bpa_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	res_t res;

	bpa_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .page_count, .address,
		.cmd_valid, .cmd, .cmd_pop
	);

	bpa_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop,
		.res_valid(out_valid), .res, .res_stall(out_stall)
	);

	assign address_res = res.address_res;
	assign ok          = res.ok;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the bitmap page allocator against its own page map model.
// Allocate and free requests go in: directed corners, a full-map fill and
// drain, then random traffic that keeps track of live runs. Both channels
// idle and stall under several load phases, and every result word is
// compared field by field with the predicted one.
// ---------------------------------------------------------------------------
module tb_top;
	import bpa_pkg::*;

	class alloc_scoreboard;
		bit   page_used [PAGES];
		int   lowest_free;
		res_t expected_q [$];
		int   errors;

		function new();
			lowest_free = 0;
			errors = 0;
			foreach (page_used[i]) page_used[i] = 1'b0;
		endfunction

		// advance the model by one request, queue its result
		function void note_request(func_t f, logic [CNT_W-1:0] cnt,
				logic [ADDR_W-1:0] addr, output res_t r);
			int run;
			int start;
			int idx;
			bit found;
			r = '0;
			found = 1'b0;
			start = 0;
			run = 0;
			if (cnt != 0 && cnt <= MAX_RUN) begin
				if (f == FUNC_ALLOC) begin
					for (int i = lowest_free; i < PAGES && !found; i++) begin
						if (page_used[i]) begin
							run = 0;
						end else begin
							run++;
							if (run == cnt) begin
								start = i + 1 - cnt;
								found = 1'b1;
							end
						end
					end
					if (found) begin
						for (int k = 0; k < cnt; k++) page_used[start + k] = 1'b1;
						r.address_res = ADDR_W'(start << PAGE_SHIFT);
						r.ok = 1'b1;
						while (lowest_free < PAGES && page_used[lowest_free])
							lowest_free++;
					end
				end else begin
					idx = addr[ADDR_W-1:PAGE_SHIFT];
					if (idx + cnt <= PAGES) begin
						for (int k = 0; k < cnt; k++) page_used[idx + k] = 1'b0;
						if (idx < lowest_free) lowest_free = idx;
						r.ok = 1'b1;
					end
				end
			end
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [ADDR_W-1:0] got_addr, logic got_ok);
			res_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected word addr=%h ok=%b", got_addr, got_ok));
			end else begin
				e = expected_q.pop_front();
				if (got_addr !== e.address_res)
					report($sformatf("address_res %h, want %h", got_addr, e.address_res));
				if (got_ok !== e.ok)
					report($sformatf("ok %b, want %b", got_ok, e.ok));
			end
		endtask
	endclass

	typedef struct {
		int start;
		int cnt;
	} run_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	logic [CNT_W-1:0]    page_count;
	logic [ADDR_W-1:0]   address;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ADDR_W-1:0]   address_res;
	logic                ok;

	alloc_scoreboard sb = new();
	run_t            live_runs [$];
	int              live_pages;
	int              idle_pct;
	int              stall_pct;
	int              cycles = 0;

	bitmap_page_allocator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.page_count  (page_count),
		.address     (address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.address_res (address_res),
		.ok          (ok)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 50000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// a word is taken at the next rising edge when valid and not stalled here
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(address_res, ok);
	end

	task send_word(func_t f, int cnt, logic [ADDR_W-1:0] addr, output res_t r);
		bit taken;
		in_valid   <= 1'b1;
		func       <= f;
		page_count <= CNT_W'(cnt);
		address    <= addr;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken) sb.note_request(f, CNT_W'(cnt), addr, r);
			@(posedge clk);
		end while (!taken);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task alloc_pages(int cnt);
		res_t r;
		send_word(FUNC_ALLOC, cnt, ADDR_W'($urandom), r);
		if (r.ok) begin
			live_runs.push_back('{int'(r.address_res >> PAGE_SHIFT), cnt});
			live_pages += cnt;
		end
	endtask

	task free_pages(int cnt, logic [ADDR_W-1:0] addr);
		res_t r;
		send_word(FUNC_FREE, cnt, addr, r);
	endtask

	task drain;
		in_valid <= 1'b0;
		wait (sb.expected_q.size() == 0);
		@(posedge clk);
	endtask

	task random_traffic(int n);
		int   pick;
		int   sel;
		run_t rn;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				alloc_pages(($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_RUN + 1, 127));
			end else if (pick < 11) begin
				free_pages($urandom_range(0, 127), ADDR_W'($urandom));
			end else if ((pick < 55 && live_pages < 300) || live_runs.size() == 0) begin
				alloc_pages(($urandom_range(99) < 85) ? $urandom_range(1, 8)
					: $urandom_range(9, MAX_RUN));
			end else begin
				sel = $urandom_range(live_runs.size() - 1);
				rn = live_runs[sel];
				live_runs.delete(sel);
				live_pages -= rn.cnt;
				free_pages(rn.cnt, ADDR_W'((rn.start << PAGE_SHIFT) | $urandom_range(4095)));
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = 1'b0;
		page_count = '0;
		address    = '0;
		idle_pct   = 0;
		stall_pct  = 0;
		live_pages = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		alloc_pages(0);
		alloc_pages(MAX_RUN + 1);
		alloc_pages(127);
		alloc_pages(1);
		alloc_pages(MAX_RUN);
		alloc_pages(3);
		free_pages(0, 24'h000000);
		free_pages(1, 24'h000FFF);
		alloc_pages(1);
		free_pages(2, 24'hFFF000);
		free_pages(1, 24'hFFFFFF);
		free_pages(MAX_RUN, 24'hFC0ABC);
		free_pages(MAX_RUN, 24'hFC1000);
		free_pages(127, 24'h000000);
		free_pages(5, 24'h800123);
		free_pages(MAX_RUN, 24'h001000);
		alloc_pages(2);
		free_pages(MAX_RUN + 2, 24'h000000);
		drain();

		// fill the map, hit the no-fit case, then empty it
		repeat (PAGES / MAX_RUN + 2) alloc_pages(MAX_RUN);
		alloc_pages(1);
		for (int b = 0; b < PAGES / MAX_RUN; b++)
			free_pages(MAX_RUN, ADDR_W'(b * MAX_RUN) << PAGE_SHIFT);
		live_runs.delete();
		live_pages = 0;

		random_traffic(440);
		drain();
		idle_pct  = 60;
		random_traffic(440);
		idle_pct  = 0;
		stall_pct = 60;
		random_traffic(440);
		idle_pct  = 25;
		stall_pct = 25;
		random_traffic(440);
		in_valid <= 1'b0;

		wait (sb.expected_q.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
